@@ sv/hck_pkg.sv @@
// Shared types, codes and helpers for the hybrid chassis kinematics core.
package hck_pkg;

  typedef enum logic {
    OP_INVERSE = 1'b0,
    OP_FORWARD = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    MISS_NONE = 3'd0,
    MISS_FL   = 3'd1,
    MISS_FR   = 3'd2,
    MISS_BL   = 3'd3,
    MISS_BR   = 3'd4
  } miss_e;

  typedef enum logic [2:0] {
    REG_ARM_FL     = 3'd0,
    REG_ARM_FR     = 3'd1,
    REG_ARM_BL     = 3'd2,
    REG_ARM_BR     = 3'd3,
    REG_HALF_TRACK = 3'd4
  } reg_e;

  localparam int unsigned ArmW      = 24;
  localparam int unsigned DenW      = ArmW + 1;
  localparam int unsigned NumW      = 34;
  // Magnitude of the numerator fits 33 bits; sixteen fraction bits are appended.
  localparam int unsigned DivBits   = NumW - 1 + 16;
  localparam int unsigned DivSteps  = 7;
  localparam int unsigned DivStages = DivBits / DivSteps;
  localparam int unsigned DivLat    = DivStages + 1;

  localparam int unsigned InW  = 232;
  localparam int unsigned OutW = 296;

  // Values carried beside the dividers from the first stage to the output.
  typedef struct packed {
    op_e                 op;
    miss_e               miss;
    logic                trk;
    logic signed [31:0]  vx;
    logic signed [31:0]  vy;
    logic signed [40:0]  rfl;
    logic signed [40:0]  rfr;
    logic signed [40:0]  rbl;
    logic signed [40:0]  rbr;
    logic signed [40:0]  rt;
    logic signed [33:0]  b1;
    logic signed [33:0]  b2;
    logic signed [26:0]  c1;
    logic signed [26:0]  c2;
    logic                neg1;
    logic                neg2;
    logic                quart;
  } pay_t;

  function automatic logic [31:0] sat32(input logic signed [44:0] x);
    logic [31:0] r;
    if (x > 45'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -45'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/hybrid_chassis_kinematics_core.sv @@
// Top level of the hybrid chassis kinematics core: operand stage, dividers and result stages.
// The core accepts one word per clock while the output side does not stall and returns one
// result word per input word, in order. The latency is set by the forward-mode quotient:
// two restoring dividers of seven stages, seven quotient bits each, followed by a saturation
// stage; inverse words ride through the same pipeline. A stall on the output holds the whole
// pipeline. Arm registers are to be written through the APB port only while no word is in
// flight; the core itself does not enforce this.
module hybrid_chassis_kinematics_core
  import hck_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // APB configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // missing_wheel[2:0], tracks_enabled[3], speed_x[35:4], speed_y[67:36],
  // turn_rate[99:68], wheel_front_left[131:100], wheel_front_right[163:132],
  // wheel_back_left[195:164], wheel_back_right[227:196], zero pad[231:228]
  input  logic [InW-1:0]   s_axis_tdata,
  // op[0]
  input  logic             s_axis_tuser,
  // Output stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // drive_front_left[31:0], drive_front_right[63:32], drive_back_left[95:64],
  // drive_back_right[127:96], track_left[159:128], track_right[191:160],
  // est_speed_x[223:192], est_speed_y[255:224], est_turn_rate[287:256],
  // divide_fault[288], zero pad[295:289]
  output logic [OutW-1:0]  m_axis_tdata
);

  // Configuration registers.
  logic [ArmW-1:0] kfl_q, kfr_q, kbl_q, kbr_q, kht_q;
  logic            wr_en;
  reg_e            wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wr_idx = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kfl_q <= '0;
      kfr_q <= '0;
      kbl_q <= '0;
      kbr_q <= '0;
      kht_q <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_ARM_FL:     kfl_q <= pwdata[ArmW-1:0];
        REG_ARM_FR:     kfr_q <= pwdata[ArmW-1:0];
        REG_ARM_BL:     kbl_q <= pwdata[ArmW-1:0];
        REG_ARM_BR:     kbr_q <= pwdata[ArmW-1:0];
        REG_HALF_TRACK: kht_q <= pwdata[ArmW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_ARM_FL:     prdata = 32'(kfl_q);
      REG_ARM_FR:     prdata = 32'(kfr_q);
      REG_ARM_BL:     prdata = 32'(kbl_q);
      REG_ARM_BR:     prdata = 32'(kbr_q);
      REG_HALF_TRACK: prdata = 32'(kht_q);
      default:        prdata = '0;
    endcase
  end

  // The pipeline moves whenever the output register is empty or being emptied.
  logic adv;
  logic out_valid_q;
  assign adv           = !out_valid_q | m_axis_tready;
  assign s_axis_tready = adv;

  // Operand stage.
  logic signed [31:0] vx, vy, wz, fl, fr, bl, br;
  logic [2:0]         miss_raw;
  miss_e              miss;
  logic signed [DenW:0] sfl, sfr, sbl, sbr, sht;
  logic signed [26:0] cfl, cfr, cbl, cbr;
  logic signed [56:0] pfl, pfr, pbl, pbr, pht;

  assign miss_raw = s_axis_tdata[2:0];
  assign miss     = (miss_raw > 3'd4) ? MISS_NONE : miss_e'(miss_raw);
  assign vx = s_axis_tdata[35:4];
  assign vy = s_axis_tdata[67:36];
  assign wz = s_axis_tdata[99:68];
  assign fl = s_axis_tdata[131:100];
  assign fr = s_axis_tdata[163:132];
  assign bl = s_axis_tdata[195:164];
  assign br = s_axis_tdata[227:196];

  assign sfl = {2'b00, kfl_q};
  assign sfr = {2'b00, kfr_q};
  assign sbl = {2'b00, kbl_q};
  assign sbr = {2'b00, kbr_q};
  assign sht = {2'b00, kht_q};
  assign cfl = 27'(sfl);
  assign cfr = 27'(sfr);
  assign cbl = 27'(sbl);
  assign cbr = 27'(sbr);

  assign pfl = wz * sfl;
  assign pfr = wz * sfr;
  assign pbl = wz * sbl;
  assign pbr = wz * sbr;
  assign pht = wz * sht;

  pay_t               pa_d, pa_q;
  logic signed [NumW-1:0] n1_d, n2_d, n1_q, n2_q;
  logic [DenW-1:0]    d1_d, d2_d, d1_q, d2_q;
  logic               va_q;

  always_comb begin
    pa_d       = '0;
    pa_d.op    = op_e'(s_axis_tuser);
    pa_d.miss  = miss;
    pa_d.trk   = s_axis_tdata[3];
    pa_d.vx    = vx;
    pa_d.vy    = vy;
    pa_d.rfl   = pfl[56:16];
    pa_d.rfr   = pfr[56:16];
    pa_d.rbl   = pbl[56:16];
    pa_d.rbr   = pbr[56:16];
    pa_d.rt    = pht[56:16];
    n1_d = '0;
    n2_d = '0;
    d1_d = '0;
    d2_d = '0;
    case (miss)
      MISS_FL: begin
        n1_d = NumW'(br) - NumW'(bl) + NumW'(fr);
        d1_d = DenW'(kbl_q) + DenW'(kfr_q);
        pa_d.b1 = NumW'(bl);  pa_d.c1 = cbl; pa_d.neg1 = 1'b0;
        pa_d.b2 = NumW'(fr);  pa_d.c2 = cfr; pa_d.neg2 = 1'b1;
      end
      MISS_FR: begin
        n1_d = NumW'(br) - NumW'(fl) - NumW'(bl);
        d1_d = DenW'(kbr_q) + DenW'(kfl_q);
        pa_d.b1 = NumW'(br);  pa_d.c1 = cbr; pa_d.neg1 = 1'b1;
        pa_d.b2 = -NumW'(fl); pa_d.c2 = cfl; pa_d.neg2 = 1'b1;
      end
      MISS_BL: begin
        n1_d = NumW'(fr) - NumW'(fl) + NumW'(br);
        d1_d = DenW'(kfl_q) + DenW'(kbr_q);
        pa_d.b1 = NumW'(fl);  pa_d.c1 = cfl; pa_d.neg1 = 1'b0;
        pa_d.b2 = -NumW'(br); pa_d.c2 = cbr; pa_d.neg2 = 1'b0;
      end
      MISS_BR: begin
        n1_d = NumW'(fr) - NumW'(bl) - NumW'(fl);
        d1_d = DenW'(kfr_q) + DenW'(kbl_q);
        pa_d.b1 = NumW'(fr);  pa_d.c1 = cfr; pa_d.neg1 = 1'b1;
        pa_d.b2 = NumW'(bl);  pa_d.c2 = cbl; pa_d.neg2 = 1'b0;
      end
      default: begin
        n1_d = NumW'(br) - NumW'(fl);
        d1_d = DenW'(kfl_q) + DenW'(kbr_q);
        n2_d = NumW'(fr) - NumW'(bl);
        d2_d = DenW'(kfr_q) + DenW'(kbl_q);
        pa_d.b1 = NumW'(fl) + NumW'(fr) + NumW'(bl) + NumW'(br);
        pa_d.b2 = -NumW'(fl) + NumW'(fr) + NumW'(bl) - NumW'(br);
        pa_d.c1 = cbr - cfl + cfr - cbl;
        pa_d.c2 = cfr - cbl - cbr + cfl;
        pa_d.neg1  = 1'b1;
        pa_d.neg2  = 1'b1;
        pa_d.quart = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q <= pa_d;
      n1_q <= n1_d;
      n2_q <= n2_d;
      d1_q <= d1_d;
      d2_q <= d2_d;
    end
  end

  // Dividers.
  logic [31:0] q1, q2;
  logic        f1, f2;

  hck_div u_div1 (
    .clk_i   (clk_i),
    .en_i    (adv),
    .num_i   (n1_q),
    .den_i   (d1_q),
    .quo_o   (q1),
    .fault_o (f1)
  );

  hck_div u_div2 (
    .clk_i   (clk_i),
    .en_i    (adv),
    .num_i   (n2_q),
    .den_i   (d2_q),
    .quo_o   (q2),
    .fault_o (f2)
  );

  // Payload and valid bits travel beside the dividers.
  pay_t pay_dl_q [DivLat];
  logic val_dl_q [DivLat];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pay_dl_q[0] <= pa_q;
      for (int i = 1; i < DivLat; i++) begin
        pay_dl_q[i] <= pay_dl_q[i-1];
      end
    end
  end

  // Turn rate estimate.
  pay_t               p1, pay_f1_q, pay_f2_q;
  logic signed [32:0] qsum;
  logic [31:0]        wz_d, wz_f1_q, wz_f2_q;
  logic               flt_d, flt_f1_q, flt_f2_q;
  logic               val_f1_q, val_f2_q;

  assign p1   = pay_dl_q[DivLat-1];
  assign qsum = $signed({q1[31], q1}) + $signed({q2[31], q2});

  always_comb begin
    if (p1.miss == MISS_NONE) begin
      wz_d  = qsum[32:1];
      flt_d = f1 | f2;
    end else begin
      wz_d  = q1;
      flt_d = f1;
    end
  end

  // Arm products of the estimated turn rate.
  logic signed [58:0] pr1, pr2;
  logic signed [42:0] m1_q, m2_q;

  assign pr1 = $signed(wz_f1_q) * pay_f1_q.c1;
  assign pr2 = $signed(wz_f1_q) * pay_f1_q.c2;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pay_f1_q <= p1;
      wz_f1_q  <= wz_d;
      flt_f1_q <= flt_d;
      pay_f2_q <= pay_f1_q;
      wz_f2_q  <= wz_f1_q;
      flt_f2_q <= flt_f1_q;
      m1_q     <= pr1[58:16];
      m2_q     <= pr2[58:16];
    end
  end

  // Result assembly.
  logic [31:0] r_fl, r_fr, r_bl, r_br, r_tl, r_tr, r_ex, r_ey, r_ez;
  logic        r_flt;
  logic [OutW-1:0] out_d, out_q;

  always_comb begin
    logic signed [44:0] x, y, z, t1, t2;
    x  = 45'(pay_f2_q.vx);
    y  = 45'(pay_f2_q.vy);
    z  = '0;
    t1 = '0;
    t2 = '0;
    r_fl = '0; r_fr = '0; r_bl = '0; r_br = '0;
    r_tl = '0; r_tr = '0; r_ex = '0; r_ey = '0; r_ez = '0;
    r_flt = 1'b0;
    if (pay_f2_q.op == OP_INVERSE) begin
      case (pay_f2_q.miss)
        MISS_FL: begin
          r_fr = sat32(y + pay_f2_q.rfr);
          r_bl = sat32(x - pay_f2_q.rbl);
          r_br = sat32(x - y);
        end
        MISS_FR: begin
          r_fl = sat32(-y - pay_f2_q.rfl);
          r_bl = sat32(x + y);
          r_br = sat32(x + pay_f2_q.rbr);
        end
        MISS_BL: begin
          r_fl = sat32(x - pay_f2_q.rfl);
          r_fr = sat32(x + y);
          r_br = sat32(-y + pay_f2_q.rbr);
        end
        MISS_BR: begin
          r_fl = sat32(x - y);
          r_fr = sat32(x + pay_f2_q.rfr);
          r_bl = sat32(y - pay_f2_q.rbl);
        end
        default: begin
          r_fl = sat32(x - y - pay_f2_q.rfl);
          r_fr = sat32(x + y + pay_f2_q.rfr);
          r_bl = sat32(x + y - pay_f2_q.rbl);
          r_br = sat32(x - y + pay_f2_q.rbr);
        end
      endcase
      if (pay_f2_q.trk) begin
        r_tl = sat32(x - pay_f2_q.rt);
        r_tr = sat32(x + pay_f2_q.rt);
      end
    end else begin
      z  = 45'(pay_f2_q.b1);
      t1 = pay_f2_q.neg1 ? z - m1_q : z + m1_q;
      z  = 45'(pay_f2_q.b2);
      t2 = pay_f2_q.neg2 ? z - m2_q : z + m2_q;
      if (pay_f2_q.quart) begin
        t1 = t1 >>> 2;
        t2 = t2 >>> 2;
      end
      r_ex  = sat32(t1);
      r_ey  = sat32(t2);
      r_ez  = wz_f2_q;
      r_flt = flt_f2_q;
    end
    out_d = {7'b0, r_flt, r_ez, r_ey, r_ex, r_tr, r_tl, r_br, r_bl, r_fr, r_fl};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      val_f1_q    <= 1'b0;
      val_f2_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DivLat; i++) begin
        val_dl_q[i] <= 1'b0;
      end
    end else if (adv) begin
      va_q        <= s_axis_tvalid;
      val_dl_q[0] <= va_q;
      for (int i = 1; i < DivLat; i++) begin
        val_dl_q[i] <= val_dl_q[i-1];
      end
      val_f1_q    <= val_dl_q[DivLat-1];
      val_f2_q    <= val_f1_q;
      out_valid_q <= val_f2_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ sv/hck_div.sv @@
// Pipelined restoring divider: (num * 2^16) / den, truncated and saturated to 32 bits.
module hck_div
  import hck_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [DenW-1:0]        den_i,
  output logic [31:0]            quo_o,
  output logic                   fault_o
);

  logic [DenW-1:0]    rem_q [DivStages];
  logic [DivBits-1:0] wrk_q [DivStages];
  logic [DenW-1:0]    den_q [DivStages];
  logic               neg_q [DivStages];

  logic [DenW-1:0]    rem_in [DivStages];
  logic [DivBits-1:0] wrk_in [DivStages];
  logic [DenW-1:0]    den_in [DivStages];
  logic               neg_in [DivStages];

  logic [NumW-1:0] mag;
  logic [31:0]     quo_q;
  logic            fault_q;

  assign mag = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_in[s] = '0;
      assign wrk_in[s] = {mag[NumW-2:0], 16'h0000};
      assign den_in[s] = den_i;
      assign neg_in[s] = num_i[NumW-1];
    end else begin : g_next
      assign rem_in[s] = rem_q[s-1];
      assign wrk_in[s] = wrk_q[s-1];
      assign den_in[s] = den_q[s-1];
      assign neg_in[s] = neg_q[s-1];
    end

    logic [DenW-1:0]    rem_d;
    logic [DivBits-1:0] wrk_d;

    // Each step shifts one dividend bit into the remainder and one quotient bit in.
    always_comb begin
      logic [DenW:0] tmp;
      logic          ge;
      rem_d = rem_in[s];
      wrk_d = wrk_in[s];
      for (int i = 0; i < DivSteps; i++) begin
        tmp   = {rem_d, wrk_d[DivBits-1]};
        ge    = (tmp >= {1'b0, den_in[s]});
        wrk_d = {wrk_d[DivBits-2:0], ge};
        rem_d = ge ? DenW'(tmp - {1'b0, den_in[s]}) : tmp[DenW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        wrk_q[s] <= wrk_d;
        den_q[s] <= den_in[s];
        neg_q[s] <= neg_in[s];
      end
    end
  end

  logic [31:0] quo_d;
  logic        fault_d;
  logic [DivBits-1:0] qm;

  always_comb begin
    qm      = wrk_q[DivStages-1];
    fault_d = (den_q[DivStages-1] == '0);
    if (fault_d) begin
      quo_d = neg_q[DivStages-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (!neg_q[DivStages-1]) begin
      quo_d = (qm > DivBits'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qm[31:0];
    end else begin
      quo_d = (qm > DivBits'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-qm[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q   <= quo_d;
      fault_q <= fault_d;
    end
  end

  assign quo_o   = quo_q;
  assign fault_o = fault_q;

endmodule
